FILE: rtl/core/ztt_pkg.sv
package ztt_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int BOARD_SIDE  = 11;
  localparam int CELLS       = BOARD_SIDE * BOARD_SIDE;
  localparam int ZW_DEPTH    = 2 * CELLS;
  localparam int ZW_AW       = $clog2(ZW_DEPTH);
  localparam int ENTRY_AW    = INDEX_BITS + 1;
  localparam int ENTRY_DEPTH = 2 ** ENTRY_AW;

  localparam int S_TDATA_W = 176;
  localparam int M_TDATA_W = 16;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_CLEAR  = 3'd1;
  localparam logic [2:0] MODE_TOGGLE = 3'd2;
  localparam logic [2:0] MODE_PROBE  = 3'd3;
  localparam logic [2:0] MODE_STORE  = 3'd4;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic signed [15:0] score;
    logic signed [15:0] depth;
    logic [63:0]        check;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] depth;
  } query_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] score;
  } result_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int ZW_W    = 96;

endpackage

FILE: rtl/core/ztt_ram.sv
module ztt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ztt_eval.sv
module ztt_eval (
  input  ztt_pkg::entry_t  entry_i,
  input  ztt_pkg::query_t  query_i,
  input  logic [63:0]      check_key_i,
  output ztt_pkg::result_t result_o
);

  import ztt_pkg::*;

  logic match;
  logic usable;

  always_comb begin
    match = entry_i.valid && (entry_i.depth >= query_i.depth) &&
            (entry_i.check == check_key_i);
    unique case (entry_i.kind)
      KIND_EXACT: usable = 1'b1;
      KIND_LOWER: usable = entry_i.score >= query_i.beta;
      KIND_UPPER: usable = entry_i.score <= query_i.alpha;
      default:    usable = 1'b0;
    endcase
    result_o.hit   = match && usable;
    result_o.score = (match && usable) ? entry_i.score : 16'sd0;
  end

endmodule

FILE: rtl/core/zobrist_transposition_table_top.sv
// An accepted word moves the block to ST_EXEC; its result word is registered
// once the output is free. No new word is taken until then, as the key and
// entry memories are read through a register before the compare or write-back.
// Reset: keys clear at once; then all 2^(INDEX_BITS+1) (8192) entry words are
// swept with s_axis_tready low to clear all valid bits.
module zobrist_transposition_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // table_select, stone, row, col, key_index_word, key_check_word, alpha, beta,
  // search_depth, entry_kind, score_in, zero pad
  input  logic [ztt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // score_out
  output logic [ztt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // hit
  output logic                            m_axis_tuser
);

  import ztt_pkg::*;

  state_e state_q, state_d;
  logic [ENTRY_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [31:0] idx_key_q, idx_key_d;
  logic [63:0] chk_key_q, chk_key_d;
  logic m_valid_q, m_valid_d;
  logic m_hit_q, m_hit_d;
  logic signed [15:0] m_score_q, m_score_d;

  logic [2:0] mode_q;
  logic on_board_q;
  logic tsel_q;
  query_t query_q;
  logic [1:0] kind_q;
  logic signed [15:0] score_q;

  logic in_tsel, in_stone;
  logic [3:0] in_row, in_col;
  logic [31:0] in_kidx;
  logic [63:0] in_kchk;
  query_t in_query;
  logic [1:0] in_kind;
  logic signed [15:0] in_score;
  logic [2:0] in_mode;

  logic accept, fire, on_board;
  logic [ZW_AW-1:0] zw_addr;
  logic [ZW_W-1:0] zw_rdata;
  logic zw_we, zw_re, en_we, en_re;
  logic [ENTRY_AW-1:0] en_waddr, en_raddr;
  entry_t en_wdata, en_rdata;
  result_t probe_res;

  assign in_mode        = s_axis_tuser;
  assign in_tsel        = s_axis_tdata[0];
  assign in_stone       = s_axis_tdata[1];
  assign in_row         = s_axis_tdata[5:2];
  assign in_col         = s_axis_tdata[9:6];
  assign in_kidx        = s_axis_tdata[41:10];
  assign in_kchk        = s_axis_tdata[105:42];
  assign in_query.alpha = s_axis_tdata[121:106];
  assign in_query.beta  = s_axis_tdata[137:122];
  assign in_query.depth = s_axis_tdata[153:138];
  assign in_kind        = s_axis_tdata[155:154];
  assign in_score       = s_axis_tdata[171:156];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  assign on_board = (32'(in_row) < BOARD_SIDE) && (32'(in_col) < BOARD_SIDE);
  assign zw_addr = ZW_AW'(32'(in_stone) * CELLS + 32'(in_row) * BOARD_SIDE + 32'(in_col));

  assign zw_we = accept && (in_mode == MODE_LOAD) && on_board;
  assign zw_re = accept && (in_mode == MODE_TOGGLE) && on_board;

  ztt_ram #(
    .Width(ZW_W),
    .Depth(ZW_DEPTH)
  ) u_zw_ram (
    .clk_i  (clk_i),
    .we_i   (zw_we),
    .waddr_i(zw_addr),
    .wdata_i({in_kchk, in_kidx}),
    .re_i   (zw_re),
    .raddr_i(zw_addr),
    .rdata_o(zw_rdata)
  );

  assign en_re    = accept && (in_mode == MODE_PROBE);
  assign en_raddr = {in_tsel, idx_key_q[INDEX_BITS-1:0]};

  always_comb begin
    if (state_q == ST_CLEAR) begin
      en_we    = 1'b1;
      en_waddr = clr_cnt_q;
      en_wdata = '0;
    end else begin
      en_we          = fire && (mode_q == MODE_STORE);
      en_waddr       = {tsel_q, idx_key_q[INDEX_BITS-1:0]};
      en_wdata.valid = 1'b1;
      en_wdata.kind  = kind_q;
      en_wdata.score = score_q;
      en_wdata.depth = query_q.depth;
      en_wdata.check = chk_key_q;
    end
  end

  ztt_ram #(
    .Width(ENTRY_W),
    .Depth(ENTRY_DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(en_waddr),
    .wdata_i(en_wdata),
    .re_i   (en_re),
    .raddr_i(en_raddr),
    .rdata_o(en_rdata)
  );

  ztt_eval u_eval (
    .entry_i    (en_rdata),
    .query_i    (query_q),
    .check_key_i(chk_key_q),
    .result_o   (probe_res)
  );

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    idx_key_d = idx_key_q;
    chk_key_d = chk_key_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_hit_d   = m_hit_q;
    m_score_d = m_score_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          m_hit_d   = 1'b0;
          m_score_d = 16'sd0;
          if (mode_q == MODE_CLEAR) begin
            idx_key_d = '0;
            chk_key_d = '0;
          end
          if (mode_q == MODE_TOGGLE && on_board_q) begin
            idx_key_d = idx_key_q ^ zw_rdata[31:0];
            chk_key_d = chk_key_q ^ zw_rdata[95:32];
          end
          if (mode_q == MODE_PROBE) begin
            m_hit_d   = probe_res.hit;
            m_score_d = probe_res.score;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      idx_key_q <= '0;
      chk_key_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      idx_key_q <= idx_key_d;
      chk_key_q <= chk_key_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_hit_q   <= m_hit_d;
    m_score_q <= m_score_d;
    if (accept) begin
      mode_q     <= in_mode;
      on_board_q <= on_board;
      tsel_q     <= in_tsel;
      query_q    <= in_query;
      kind_q     <= in_kind;
      score_q    <= in_score;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_score_q;
  assign m_axis_tuser  = m_hit_q;

endmodule
